>>> sv/hgsd_pkg.sv
// Shared types, constants and helpers for the glyph segment decoder.
`timescale 1ns / 1ps
package hgsd_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] REG_FLAGS     = 3'd0;
  localparam logic [2:0] REG_SCALE     = 3'd1;
  localparam logic [2:0] REG_ASPECT    = 3'd2;
  localparam logic [2:0] REG_PADDING   = 3'd3;
  localparam logic [2:0] REG_SHEAR_X   = 3'd4;
  localparam logic [2:0] REG_SHEAR_Y   = 3'd5;
  localparam logic [2:0] REG_GLYPH_ROT = 3'd6;
  localparam logic [2:0] REG_STR_ROT   = 3'd7;

  localparam logic OP_START = 1'b0;
  localparam logic OP_GLYPH = 1'b1;

  localparam logic [1:0] PH_LEFT  = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_X     = 2'd2;
  localparam logic [1:0] PH_Y     = 2'd3;

  localparam logic [3:0]         FLAGS_RESET   = 4'h0;
  localparam logic [15:0]        SCALE_RESET   = 16'd256;
  localparam logic [31:0]        ASPECT_RESET  = 32'h1000_1000;
  localparam logic signed [23:0] PADDING_RESET = -24'sd256;

  localparam logic signed [8:0]  CHAR_BASE  = 9'sd82;
  localparam logic [7:0]         CHAR_SPACE = 8'd32;
  localparam logic signed [47:0] ONE_PIXEL  = 48'sd256;

  typedef struct packed {
    logic [3:0]         flags;
    logic [15:0]        scale;
    logic [31:0]        aspect;
    logic signed [23:0] padding;
    logic signed [15:0] shear_x;
    logic [31:0]        shear_y;
    logic [31:0]        glyph_rot;
    logic [31:0]        str_rot;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [23:0] x2;
    logic signed [23:0] y2;
    logic signed [23:0] pen_x;
    logic signed [23:0] pen_y;
    logic signed [15:0] str_x;
    logic signed [15:0] str_y;
  } job_t;

  typedef struct packed {
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [23:0] x2;
    logic signed [23:0] y2;
  } res_t;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) r = 24'sh7FFFFF;
    else if (v < -48'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

>>> sv/hgsd_fifo.sv
// Small first-word-fall-through queue.
`timescale 1ns / 1ps
module hgsd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end
endmodule

>>> sv/hgsd_front.sv
// Front end: takes glyph words, tracks pen state and emits stroke jobs.
`timescale 1ns / 1ps
module hgsd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                op,
  input  logic [7:0]          glyph_byte,
  input  logic signed [15:0]  origin_x,
  input  logic signed [15:0]  origin_y,
  input  logic                glyph_last,
  input  hgsd_pkg::cfg_t      cfg,
  input  logic                job_full,
  output logic                job_push,
  output hgsd_pkg::job_t      job
);
  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_MUL1  = 2'd1;
  localparam logic [1:0] F_MUL2  = 2'd2;
  localparam logic [1:0] F_APPLY = 2'd3;

  logic [1:0]         state, state_next;
  logic [1:0]         phase;
  logic               sel, lifted, last_r;
  logic [7:0]         byte_r, held;
  logic signed [23:0] pen_x, pen_y, prev_x, prev_y, rm;
  logic signed [15:0] str_x, str_y;
  logic signed [25:0] p1;
  logic signed [42:0] p2;
  logic signed [30:0] off_a, off_b;

  logic [7:0]         mul_byte;
  logic signed [8:0]  d;
  logic signed [16:0] hasp, vasp, asp;
  logic signed [23:0] pen_sub, px, py, rm_new, base_x, adv;
  logic               want_job, stall;

  assign full = (state != F_IDLE);

  assign mul_byte = (phase == hgsd_pkg::PH_Y && !sel) ? held : byte_r;
  assign d        = $signed({1'b0, mul_byte}) - hgsd_pkg::CHAR_BASE;
  assign hasp     = 17'($signed(cfg.aspect[31:16]));
  assign vasp     = 17'($signed(cfg.aspect[15:0]));

  always_comb begin
    if (phase == hgsd_pkg::PH_Y) asp = sel ? vasp : hasp;
    else asp = (hasp < 0) ? -hasp : hasp;
  end

  assign p2       = 43'(p1) * 43'(asp);
  assign pen_sub  = hgsd_pkg::sat24(48'(pen_x) - 48'(off_b));
  assign px       = hgsd_pkg::sat24(48'(pen_x) + 48'(off_a));
  assign py       = hgsd_pkg::sat24(48'(pen_y) + 48'(off_b));
  assign base_x   = (phase == hgsd_pkg::PH_LEFT) ? pen_sub : pen_x;
  assign adv      = hgsd_pkg::sat24(48'(base_x) + 48'(rm_new) + 48'(cfg.padding));
  assign want_job = (state == F_APPLY) && (phase == hgsd_pkg::PH_Y) && !lifted;
  assign stall    = want_job && job_full;
  assign job_push = want_job && !job_full;

  always_comb begin
    unique case (phase)
      hgsd_pkg::PH_LEFT:  rm_new = '0;
      hgsd_pkg::PH_RIGHT: rm_new = hgsd_pkg::sat24(48'(off_b));
      default:            rm_new = rm;
    endcase
  end

  always_comb begin
    job.x1    = prev_x;
    job.y1    = prev_y;
    job.x2    = px;
    job.y2    = py;
    job.pen_x = pen_x;
    job.pen_y = pen_y;
    job.str_x = str_x;
    job.str_y = str_y;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (push && op == hgsd_pkg::OP_GLYPH) begin
          state_next = (phase == hgsd_pkg::PH_X) ? F_APPLY : F_MUL1;
        end
      end
      F_MUL1:  state_next = F_MUL2;
      F_MUL2:  state_next = (phase == hgsd_pkg::PH_Y && !sel) ? F_MUL1 : F_APPLY;
      F_APPLY: state_next = stall ? F_APPLY : F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    p1 <= 26'(d) * 26'($signed({1'b0, cfg.scale}));
    if (state == F_IDLE && push) begin
      byte_r <= glyph_byte;
      last_r <= glyph_last;
    end
    if (state == F_MUL2) begin
      if (phase == hgsd_pkg::PH_Y && !sel) off_a <= 31'((p2 + 43'sd2048) >>> 12);
      else off_b <= 31'((p2 + 43'sd2048) >>> 12);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= F_IDLE;
      phase  <= hgsd_pkg::PH_LEFT;
      sel    <= 1'b0;
      lifted <= 1'b1;
      held   <= '0;
      pen_x  <= '0;
      pen_y  <= '0;
      str_x  <= '0;
      str_y  <= '0;
      prev_x <= '0;
      prev_y <= '0;
      rm     <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE && push) begin
        sel <= 1'b0;
        if (op == hgsd_pkg::OP_START) begin
          str_x  <= origin_x;
          str_y  <= origin_y;
          pen_x  <= {origin_x, 8'h00};
          pen_y  <= {origin_y, 8'h00};
          phase  <= hgsd_pkg::PH_LEFT;
          lifted <= 1'b1;
        end
      end
      if (state == F_MUL2 && phase == hgsd_pkg::PH_Y && !sel) begin
        sel <= 1'b1;
      end
      if (state == F_APPLY && !stall) begin
        rm <= rm_new;
        unique case (phase)
          hgsd_pkg::PH_LEFT: begin
            pen_x <= pen_sub;
            phase <= hgsd_pkg::PH_RIGHT;
          end
          hgsd_pkg::PH_RIGHT: phase <= hgsd_pkg::PH_X;
          hgsd_pkg::PH_X: begin
            if (byte_r == hgsd_pkg::CHAR_SPACE) begin
              lifted <= 1'b1;
            end else begin
              held  <= byte_r;
              phase <= hgsd_pkg::PH_Y;
            end
          end
          default: begin
            lifted <= 1'b0;
            prev_x <= px;
            prev_y <= py;
            phase  <= hgsd_pkg::PH_X;
          end
        endcase
        if (last_r) begin
          pen_x  <= adv;
          phase  <= hgsd_pkg::PH_LEFT;
          lifted <= 1'b1;
        end
      end
    end
  end
endmodule

>>> sv/hgsd_back.sv
// Back end: runs shears and rotations on both ends of a stroke with one multiplier.
`timescale 1ns / 1ps
module hgsd_back (
  input  logic           clk,
  input  logic           rst,
  input  hgsd_pkg::cfg_t cfg,
  input  logic           job_empty,
  output logic           job_pop,
  input  hgsd_pkg::job_t job,
  input  logic           res_full,
  output logic           res_push,
  output hgsd_pkg::res_t res
);
  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_LOAD  = 4'd1;
  localparam logic [3:0] B_SX1   = 4'd2;
  localparam logic [3:0] B_SX2   = 4'd3;
  localparam logic [3:0] B_SY1   = 4'd4;
  localparam logic [3:0] B_SY2   = 4'd5;
  localparam logic [3:0] B_SY3   = 4'd6;
  localparam logic [3:0] B_GPRE  = 4'd7;
  localparam logic [3:0] B_ROT1  = 4'd8;
  localparam logic [3:0] B_ROT2  = 4'd9;
  localparam logic [3:0] B_ROT3  = 4'd10;
  localparam logic [3:0] B_ROT4  = 4'd11;
  localparam logic [3:0] B_ROT5  = 4'd12;
  localparam logic [3:0] B_GPOST = 4'd13;
  localparam logic [3:0] B_FIN   = 4'd14;
  localparam logic [3:0] B_PUSH  = 4'd15;

  logic [3:0]         state, state_next;
  logic               k, rot_sel;
  hgsd_pkg::job_t     jr;
  logic signed [47:0] x, y, tmp;
  logic signed [63:0] prod, acc;
  logic signed [47:0] mul_a;
  logic signed [15:0] mul_b, rs, rc;
  logic signed [47:0] sx256, sy256, pxw, pyw;
  logic signed [23:0] r0x, r0y, fin_x, fin_y;

  function automatic logic [3:0] after_stage(input logic [1:0] lvl, input logic [3:0] f);
    logic [3:0] n;
    n = B_FIN;
    if (f[3]) n = B_ROT1;
    if (f[2] && lvl <= 2'd2) n = B_GPRE;
    if (f[1] && lvl <= 2'd1) n = B_SY1;
    if (f[0] && lvl == 2'd0) n = B_SX1;
    return n;
  endfunction

  function automatic logic signed [47:0] rnd(input logic signed [63:0] v, input int sh);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    return t[47:0];
  endfunction

  assign sx256 = 48'($signed({jr.str_x, 8'h00}));
  assign sy256 = 48'($signed({jr.str_y, 8'h00}));
  assign pxw   = 48'(jr.pen_x);
  assign pyw   = 48'(jr.pen_y);
  assign rs    = rot_sel ? $signed(cfg.glyph_rot[31:16]) : $signed(cfg.str_rot[31:16]);
  assign rc    = rot_sel ? $signed(cfg.glyph_rot[15:0]) : $signed(cfg.str_rot[15:0]);
  assign fin_x = hgsd_pkg::sat24(x + sx256);
  assign fin_y = hgsd_pkg::sat24(y + sy256);

  assign job_pop  = (state == B_IDLE) && !job_empty;
  assign res_push = (state == B_PUSH) && !res_full;
  assign res.x1   = r0x;
  assign res.y1   = r0y;
  assign res.x2   = tmp[23:0];
  assign res.y2   = acc[23:0];

  always_comb begin
    unique case (state)
      B_SX1:   begin mul_a = y; mul_b = cfg.shear_x; end
      B_SY1:   begin mul_a = x; mul_b = $signed(cfg.shear_y[31:16]); end
      B_SY2:   begin mul_a = y; mul_b = $signed(cfg.shear_y[15:0]); end
      B_ROT1:  begin mul_a = x; mul_b = rc; end
      B_ROT2:  begin mul_a = y; mul_b = rs; end
      B_ROT3:  begin mul_a = x; mul_b = rs; end
      default: begin mul_a = y; mul_b = rc; end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!job_empty) state_next = B_LOAD;
      B_LOAD:  state_next = after_stage(2'd0, cfg.flags);
      B_SX1:   state_next = B_SX2;
      B_SX2:   state_next = after_stage(2'd1, cfg.flags);
      B_SY1:   state_next = B_SY2;
      B_SY2:   state_next = B_SY3;
      B_SY3:   state_next = after_stage(2'd2, cfg.flags);
      B_GPRE:  state_next = B_ROT1;
      B_ROT1:  state_next = B_ROT2;
      B_ROT2:  state_next = B_ROT3;
      B_ROT3:  state_next = B_ROT4;
      B_ROT4:  state_next = B_ROT5;
      B_ROT5:  state_next = rot_sel ? B_GPOST : B_FIN;
      B_GPOST: state_next = after_stage(2'd3, cfg.flags);
      B_FIN:   state_next = k ? B_PUSH : B_LOAD;
      B_PUSH:  if (!res_full) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    unique case (state)
      B_IDLE: if (!job_empty) jr <= job;
      B_LOAD: begin
        x <= (k ? 48'(jr.x2) : 48'(jr.x1)) - sx256;
        y <= (k ? 48'(jr.y2) : 48'(jr.y1)) - sy256;
      end
      B_SX2: x <= x + rnd(prod, 12);
      B_SY2: acc <= prod;
      B_SY3: y <= rnd(acc + prod, 14) + hgsd_pkg::ONE_PIXEL;
      B_GPRE: begin
        x <= x + sx256 - pxw;
        y <= y + sy256 - pyw;
      end
      B_ROT2: acc <= prod;
      B_ROT3: tmp <= rnd(acc - prod, 14);
      B_ROT4: acc <= prod;
      B_ROT5: begin
        x <= tmp;
        y <= rnd(acc + prod, 14);
      end
      B_GPOST: begin
        x <= x + pxw - sx256;
        y <= y + pyw - sy256;
      end
      B_FIN: begin
        if (k) begin
          tmp <= 48'(fin_x);
          acc <= 64'(fin_y);
        end else begin
          r0x <= fin_x;
          r0y <= fin_y;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      k       <= 1'b0;
      rot_sel <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_IDLE) k <= 1'b0;
      else if (state == B_FIN) k <= 1'b1;
      if (state == B_GPRE) rot_sel <= 1'b1;
      else if (state_next == B_ROT1) rot_sel <= 1'b0;
    end
  end
endmodule

>>> sv/hershey_glyph_segment_decoder_top.sv
// Top level: register file, front end, job queue, back end and result queue.
`timescale 1ns / 1ps
// Glyph bytes are taken one at a time: a coordinate x byte or space goes
// straight to apply, a margin byte runs the two chained scale multiplies of
// the front end and a y byte runs them twice, for the held x byte and
// itself; a string start only loads the origin. Each stroke then passes
// through the back end, whose single 48x16 multiplier works through shears
// and rotations of both end points in turn. A two-word job queue lets bytes
// flow while strokes are worked off; a two-word result queue holds segments
// until they are popped. Write registers only while the block is idle.
module hershey_glyph_segment_decoder_top #(
  parameter int QUEUE_DEPTH = hgsd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic [7:0]         glyph_byte,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic               glyph_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] seg_x1,
  output logic signed [23:0] seg_y1,
  output logic signed [23:0] seg_x2,
  output logic signed [23:0] seg_y2
);
  hgsd_pkg::cfg_t cfg;
  hgsd_pkg::job_t job_in, job_out;
  hgsd_pkg::res_t res_in, res_out;
  logic           job_push, job_full, job_pop, job_empty;
  logic           res_push, res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flags     <= hgsd_pkg::FLAGS_RESET;
      cfg.scale     <= hgsd_pkg::SCALE_RESET;
      cfg.aspect    <= hgsd_pkg::ASPECT_RESET;
      cfg.padding   <= hgsd_pkg::PADDING_RESET;
      cfg.shear_x   <= '0;
      cfg.shear_y   <= '0;
      cfg.glyph_rot <= '0;
      cfg.str_rot   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hgsd_pkg::REG_FLAGS:     cfg.flags     <= cfg_data[3:0];
        hgsd_pkg::REG_SCALE:     cfg.scale     <= cfg_data[15:0];
        hgsd_pkg::REG_ASPECT:    cfg.aspect    <= cfg_data;
        hgsd_pkg::REG_PADDING:   cfg.padding   <= cfg_data[23:0];
        hgsd_pkg::REG_SHEAR_X:   cfg.shear_x   <= cfg_data[15:0];
        hgsd_pkg::REG_SHEAR_Y:   cfg.shear_y   <= cfg_data;
        hgsd_pkg::REG_GLYPH_ROT: cfg.glyph_rot <= cfg_data;
        default:                 cfg.str_rot   <= cfg_data;
      endcase
    end
  end

  hgsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .glyph_byte (glyph_byte),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .glyph_last (glyph_last),
    .cfg        (cfg),
    .job_full   (job_full),
    .job_push   (job_push),
    .job        (job_in)
  );

  hgsd_fifo #(.W($bits(hgsd_pkg::job_t)), .DEPTH(QUEUE_DEPTH)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .full  (job_full),
    .din   (job_in),
    .pop   (job_pop),
    .empty (job_empty),
    .dout  (job_out)
  );

  hgsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job_out),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  hgsd_fifo #(.W($bits(hgsd_pkg::res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign seg_x1 = res_out.x1;
  assign seg_y1 = res_out.y1;
  assign seg_x2 = res_out.x2;
  assign seg_y2 = res_out.y2;
endmodule
